### rtl/spiral_order_reader_assert.svh
// Assertion helpers for the RTL; included by sor_ctrl.
`ifndef SPIRAL_ORDER_READER_ASSERT_SVH
`define SPIRAL_ORDER_READER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SOR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spiral_order_reader: check failed");

// Next-cycle implication, disabled while reset is high.
`define SOR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spiral_order_reader: check failed");

`endif

### rtl/sor_pkg.sv
`default_nettype none

package sor_pkg;

   localparam int ELEMENT_WIDTH = 32;
   localparam int SIZE_WIDTH    = 5;

   // configuration register indexes
   localparam logic CSR_ROW_COUNT    = 1'b0;
   localparam logic CSR_COLUMN_COUNT = 1'b1;

   // input item codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic                            op;
      logic signed [ELEMENT_WIDTH-1:0] element_in;
   } sor_req_type;

   typedef struct packed {
      logic signed [ELEMENT_WIDTH-1:0] element_out;
      logic                            final_element;
   } sor_rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_FETCH
   } sor_state_type;

   typedef enum logic [1:0] {
      DIR_RIGHT,
      DIR_DOWN,
      DIR_LEFT,
      DIR_UP
   } sor_dir_type;

   typedef struct packed {
      logic load_write;
      logic drain;
      logic capture;
   } sor_cmd_type;

   typedef struct packed {
      logic load_room;
      logic matrix_full;
   } sor_status_type;

endpackage

`default_nettype wire

### rtl/spiral_order_reader.sv
// Spiral order reader: a matrix buffer that is filled in row-major order and
// read back in clockwise spiral order (top row, right column, bottom row,
// left column, then inward).
// req channel: op = load (element_in is stored, no result) or drain (one
// result). Loads past a full matrix and drains before it is full are
// accepted and dropped. rsp channel: element_out plus final_element on the
// last element of the spiral; after it, loading starts over.
// csr port: csr_we writes row_count (index 0) or column_count (index 1);
// any write discards loaded data and restarts the walk. Write only when idle.
// Flow: loads stream at one per cycle while req_stall is low. A drain
// goes through a registered store read, then the fetch state of the
// controller, in which the result is captured into the output register
// and rsp_valid is raised. A new item may enter after the fetch.
// The input is held off only during that fetch or while a result waits
// under rsp_stall; a result under stall holds until it transfers.
// Reset (synchronous): sizes go to 1 x 1, pointers clear, no result pending.
// Store contents are not cleared and need not be: each entry is written
// before it is read.
`default_nettype none

module spiral_order_reader #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire sor_pkg::sor_req_type           req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output sor_pkg::sor_rsp_type                rsp_data,
   input  wire logic                           csr_we,
   input  wire logic                           csr_index,
   input  wire logic [sor_pkg::SIZE_WIDTH-1:0] csr_wdata
);

   sor_pkg::sor_cmd_type    cmd;
   sor_pkg::sor_status_type status;

   sor_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sor_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .element_in (req_data.element_in),
      .cmd        (cmd),
      .status     (status),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/sor_ctrl.sv
`default_nettype none

module sor_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_op,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire sor_pkg::sor_status_type status,
   output sor_pkg::sor_cmd_type         cmd
);

   sor_pkg::sor_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic take_ok;

   // a new item may enter in the same cycle the pending result transfers
   assign take_ok = (state_ff == sor_pkg::ST_IDLE) && !(rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sor_pkg::ST_IDLE: begin
            if (req_valid && take_ok && (req_op == sor_pkg::OP_DRAIN) &&
                status.matrix_full) begin
               state_in = sor_pkg::ST_FETCH;
            end
         end
         sor_pkg::ST_FETCH: begin
            state_in = sor_pkg::ST_IDLE;
         end
         default: begin
            state_in = sor_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall       = !take_ok;
      cmd.load_write  = req_valid && take_ok && (req_op == sor_pkg::OP_LOAD) &&
                        status.load_room;
      cmd.drain       = req_valid && take_ok && (req_op == sor_pkg::OP_DRAIN) &&
                        status.matrix_full;
      cmd.capture     = (state_ff == sor_pkg::ST_FETCH);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.capture) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sor_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`include "spiral_order_reader_assert.svh"

   `SOR_ASSERT_NOW(capture_into_empty, clock, reset, cmd.capture, !rsp_valid_ff)
   `SOR_ASSERT_NEXT(drain_goes_fetch, clock, reset, cmd.drain,
                    (state_ff == sor_pkg::ST_FETCH) && req_stall)
   `SOR_ASSERT_NEXT(fetch_shows_result, clock, reset, state_ff == sor_pkg::ST_FETCH,
                    rsp_valid_ff && (state_ff == sor_pkg::ST_IDLE))
   `SOR_ASSERT_NEXT(stalled_result_kept, clock, reset, rsp_valid_ff && rsp_stall,
                    rsp_valid_ff)

endmodule

`default_nettype wire

### rtl/sor_datapath.sv
`default_nettype none

module sor_datapath #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic                        csr_index,
   input  wire logic [sor_pkg::SIZE_WIDTH-1:0] csr_wdata,
   input  wire logic signed [sor_pkg::ELEMENT_WIDTH-1:0] element_in,
   input  wire sor_pkg::sor_cmd_type        cmd,
   output sor_pkg::sor_status_type          status,
   output sor_pkg::sor_rsp_type             rsp_data
);

   localparam int DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int SW      = sor_pkg::SIZE_WIDTH;

   function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v,
                                                input int max_size);
      logic [SW-1:0] r;
      r = v;
      if (v == '0) begin
         r = SW'(1);
      end else if (int'(v) > max_size) begin
         r = SW'(max_size);
      end
      return r;
   endfunction

   logic [SW-1:0] row_ff, row_in, col_ff, col_in;
   logic [SW-1:0] rows_cur, cols_cur, rows_next, cols_next;
   logic [2*SW-1:0] total;
   logic [COUNT_W-1:0] loaded_ff, loaded_in, emitted_ff, emitted_in, emitted_plus;
   logic [SW-1:0] top_ff, top_in, bottom_ff, bottom_in;
   logic [SW-1:0] left_ff, left_in, right_ff, right_in;
   sor_pkg::sor_dir_type dir_ff, dir_in;
   logic [ROW_W-1:0] crow_ff, crow_in;
   logic [COL_W-1:0] ccol_ff, ccol_in;
   logic [ROW_W+SW:0] addr_full;
   logic [ADDR_W-1:0] rd_addr;
   logic last, restart, cfg_write;

   logic signed [sor_pkg::ELEMENT_WIDTH-1:0] store_mem [DEPTH];
   logic signed [sor_pkg::ELEMENT_WIDTH-1:0] rd_data_ff, out_element_ff;
   logic last_ff, out_final_ff;

   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      cfg_write = csr_we;
      if (csr_we) begin
         unique case (csr_index)
            sor_pkg::CSR_ROW_COUNT:    row_in = csr_wdata;
            sor_pkg::CSR_COLUMN_COUNT: col_in = csr_wdata;
            default:                   cfg_write = 1'b0;
         endcase
      end
   end

   assign rows_cur  = clamp_size(row_ff, MAX_ROWS);
   assign cols_cur  = clamp_size(col_ff, MAX_COLS);
   assign rows_next = clamp_size(row_in, MAX_ROWS);
   assign cols_next = clamp_size(col_in, MAX_COLS);
   assign total     = rows_cur * cols_cur;

   assign status.load_room   = (loaded_ff < total);
   assign status.matrix_full = !(loaded_ff < total);

   assign emitted_plus = emitted_ff + 1'b1;
   assign last         = (emitted_plus >= total);
   assign restart      = cfg_write || (cmd.drain && last);

   // row-major address of the cursor
   assign addr_full = crow_ff * cols_cur + ccol_ff;
   assign rd_addr   = addr_full[ADDR_W-1:0];

   always_comb begin
      loaded_in  = loaded_ff;
      emitted_in = emitted_ff;
      top_in     = top_ff;
      bottom_in  = bottom_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      dir_in     = dir_ff;
      crow_in    = crow_ff;
      ccol_in    = ccol_ff;
      if (cmd.load_write) begin
         loaded_in = loaded_ff + 1'b1;
      end
      if (cmd.drain) begin
         emitted_in = emitted_plus;
         // step the cursor; at a corner shrink the side just walked and turn
         unique case (dir_ff)
            sor_pkg::DIR_RIGHT: begin
               if (ccol_ff < right_ff) begin
                  ccol_in = ccol_ff + 1'b1;
               end else begin
                  top_in  = top_ff + 1'b1;
                  dir_in  = sor_pkg::DIR_DOWN;
                  crow_in = ROW_W'(top_ff + 1'b1);
               end
            end
            sor_pkg::DIR_DOWN: begin
               if (crow_ff < bottom_ff) begin
                  crow_in = crow_ff + 1'b1;
               end else begin
                  right_in = right_ff - 1'b1;
                  dir_in   = sor_pkg::DIR_LEFT;
                  ccol_in  = COL_W'(right_ff - 1'b1);
               end
            end
            sor_pkg::DIR_LEFT: begin
               if (ccol_ff > left_ff) begin
                  ccol_in = ccol_ff - 1'b1;
               end else begin
                  bottom_in = bottom_ff - 1'b1;
                  dir_in    = sor_pkg::DIR_UP;
                  crow_in   = ROW_W'(bottom_ff - 1'b1);
               end
            end
            sor_pkg::DIR_UP: begin
               if (crow_ff > top_ff) begin
                  crow_in = crow_ff - 1'b1;
               end else begin
                  left_in = left_ff + 1'b1;
                  dir_in  = sor_pkg::DIR_RIGHT;
                  ccol_in = COL_W'(left_ff + 1'b1);
               end
            end
            default: begin
               dir_in = sor_pkg::DIR_RIGHT;
            end
         endcase
      end
      if (restart) begin
         loaded_in  = '0;
         emitted_in = '0;
         top_in     = '0;
         bottom_in  = rows_next - 1'b1;
         left_in    = '0;
         right_in   = cols_next - 1'b1;
         dir_in     = sor_pkg::DIR_RIGHT;
         crow_in    = '0;
         ccol_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= SW'(1);
         col_ff     <= SW'(1);
         loaded_ff  <= '0;
         emitted_ff <= '0;
         top_ff     <= '0;
         bottom_ff  <= '0;
         left_ff    <= '0;
         right_ff   <= '0;
         dir_ff     <= sor_pkg::DIR_RIGHT;
         crow_ff    <= '0;
         ccol_ff    <= '0;
      end else begin
         row_ff     <= row_in;
         col_ff     <= col_in;
         loaded_ff  <= loaded_in;
         emitted_ff <= emitted_in;
         top_ff     <= top_in;
         bottom_ff  <= bottom_in;
         left_ff    <= left_in;
         right_ff   <= right_in;
         dir_ff     <= dir_in;
         crow_ff    <= crow_in;
         ccol_ff    <= ccol_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_write) begin
         store_mem[loaded_ff[ADDR_W-1:0]] <= element_in;
      end
      if (cmd.drain) begin
         rd_data_ff <= store_mem[rd_addr];
         last_ff    <= last;
      end
      if (cmd.capture) begin
         out_element_ff <= rd_data_ff;
         out_final_ff   <= last_ff;
      end
   end

   assign rsp_data.element_out   = out_element_ff;
   assign rsp_data.final_element = out_final_ff;

endmodule

`default_nettype wire
